@@ rtl/ogic_pkg.sv @@
`default_nettype none
package ogic_pkg;

   localparam int unsigned DEF_MAX_ROWS = 32;
   localparam int unsigned DEF_MAX_COLS = 32;

   localparam int unsigned COORD_W = 5;
   localparam int unsigned CFG_W   = 6;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned REG_W   = 1;

   localparam logic [REG_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [REG_W-1:0] REG_GRID_COLS = 1'b1;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_LAND,
      ST_NBR,
      ST_NBR_LAND,
      ST_FIND,
      ST_SIZE_A,
      ST_SIZE_B,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

@@ rtl/ogic_if.sv @@
`default_nettype none
interface ogic_req_if;
   logic                          valid;
   logic                          ready;
   logic [ogic_pkg::COORD_W-1:0] cell_row;
   logic [ogic_pkg::COORD_W-1:0] cell_col;
   modport source (output valid, cell_row, cell_col, input ready);
   modport sink (input valid, cell_row, cell_col, output ready);
endinterface

interface ogic_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ogic_pkg::COUNT_W-1:0] island_count;
   logic                          out_of_range;
   modport source (output valid, island_count, out_of_range, input ready);
   modport sink (input valid, island_count, out_of_range, output ready);
endinterface

interface ogic_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ogic_pkg::REG_W-1:0] reg_index;
   logic [ogic_pkg::CFG_W-1:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

@@ rtl/online_grid_island_counter.sv @@
// Channel   Direction  Payload
// req_chan  in         cell_row, cell_col
// rsp_chan  out        island_count, out_of_range
// csr_chan  in         reg_index, wr_data (grid_rows, grid_cols)
//
// One request is handled at a time. An out-of-range cell goes straight to the response, and
// a cell already land is answered once its land bit is read. A new land cell is marked as its
// own set and counted; then the four neighbours are taken in turn: one outside the grid or of
// water is skipped, for one of land the parent walk runs to both roots, and distinct roots
// are merged by size, lowering the count by one. The walks are serial, as the parent memory
// has a single read port. After reset the land memory is cleared cell by cell with no
// request taken. A response is held until taken; no new request is taken meanwhile.
`default_nettype none
module online_grid_island_counter #(
   parameter int unsigned MAX_ROWS = ogic_pkg::DEF_MAX_ROWS,
   parameter int unsigned MAX_COLS = ogic_pkg::DEF_MAX_COLS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ogic_req_if.sink    req_chan,
   ogic_rsp_if.source  rsp_chan,
   ogic_csr_if.sink    csr_chan
);

   localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
   localparam int unsigned CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int unsigned CW     = ogic_pkg::COUNT_W;
   localparam int unsigned GW     = ogic_pkg::CFG_W;
   localparam int unsigned XW     = ogic_pkg::COORD_W;

   logic              land_mem_ff [CELLS];
   logic [CELL_W-1:0] par_mem_ff [CELLS];
   logic [CW-1:0]     size_mem_ff [CELLS];

   logic              land_rd_ff;
   logic [CELL_W-1:0] par_rd_ff;
   logic [CW-1:0]     size_rd_ff;

   ogic_pkg::state_type state_ff, state_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [XW-1:0]     row_ff, row_in, col_ff, col_in;
   logic [CELL_W-1:0] node_ff, node_in, adj_ff, adj_in, cur_ff, cur_in, root_u_ff, root_u_in;
   logic [CW-1:0]     size_u_ff, size_u_in, total_ff, total_in;
   logic [1:0]        dir_ff, dir_in;
   logic              second_ff, second_in, oor_ff, oor_in;
   logic [GW-1:0]     grid_rows_ff, grid_cols_ff;

   logic              land_we, land_wd, par_we, size_we;
   logic [CELL_W-1:0] land_wa, land_ra, par_wa, par_wd, par_ra, size_wa, size_ra;
   logic [CW-1:0]     size_wd;

   logic [GW-1:0]     rows_eff, cols_eff;
   logic              req_oor, nb_ok;
   logic [GW-1:0]     row6, col6, ar, ac;
   logic [CELL_W-1:0] node_calc, adj_calc;

   assign rows_eff = ({3'b000, grid_rows_ff} > 9'(MAX_ROWS)) ? GW'(MAX_ROWS) : grid_rows_ff;
   assign cols_eff = ({3'b000, grid_cols_ff} > 9'(MAX_COLS)) ? GW'(MAX_COLS) : grid_cols_ff;
   assign req_oor  = ({1'b0, req_chan.cell_row} >= rows_eff)
                     || ({1'b0, req_chan.cell_col} >= cols_eff);
   assign row6     = {1'b0, row_ff};
   assign col6     = {1'b0, col_ff};
   assign node_calc = CELL_W'(12'(row_ff * cols_eff) + 12'(col_ff));
   assign adj_calc  = CELL_W'(13'(ar * cols_eff) + 13'(ac));

   always_comb begin
      nb_ok = 1'b0;
      ar    = row6;
      ac    = col6;
      case (dir_ff)
         ogic_pkg::DIR_UP: begin
            nb_ok = (row6 != '0);
            ar    = row6 - 6'd1;
         end
         ogic_pkg::DIR_RIGHT: begin
            nb_ok = ((col6 + 6'd1) < cols_eff);
            ac    = col6 + 6'd1;
         end
         ogic_pkg::DIR_DOWN: begin
            nb_ok = ((row6 + 6'd1) < rows_eff);
            ar    = row6 + 6'd1;
         end
         default: begin
            nb_ok = (col6 != '0);
            ac    = col6 - 6'd1;
         end
      endcase
   end

   assign req_chan.ready     = (state_ff == ogic_pkg::ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ogic_pkg::ST_RESP);
   assign rsp_chan.island_count = total_ff;
   assign rsp_chan.out_of_range = oor_ff;
   assign csr_chan.ready     = 1'b1;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      node_in   = node_ff;
      adj_in    = adj_ff;
      cur_in    = cur_ff;
      root_u_in = root_u_ff;
      size_u_in = size_u_ff;
      total_in  = total_ff;
      dir_in    = dir_ff;
      second_in = second_ff;
      oor_in    = oor_ff;
      land_we   = 1'b0;
      land_wa   = node_ff;
      land_wd   = 1'b1;
      land_ra   = node_ff;
      par_we    = 1'b0;
      par_wa    = node_ff;
      par_wd    = node_ff;
      par_ra    = cur_ff;
      size_we   = 1'b0;
      size_wa   = node_ff;
      size_wd   = CW'(1);
      size_ra   = root_u_ff;
      case (state_ff)
         ogic_pkg::ST_CLEAR: begin
            land_we = 1'b1;
            land_wa = clr_ff;
            land_wd = 1'b0;
            clr_in  = clr_ff + CELL_W'(1);
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               state_in = ogic_pkg::ST_IDLE;
            end
         end
         ogic_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               row_in   = req_chan.cell_row;
               col_in   = req_chan.cell_col;
               oor_in   = req_oor;
               state_in = req_oor ? ogic_pkg::ST_RESP : ogic_pkg::ST_INDEX;
            end
         end
         ogic_pkg::ST_INDEX: begin
            node_in  = node_calc;
            land_ra  = node_calc;
            state_in = ogic_pkg::ST_LAND;
         end
         ogic_pkg::ST_LAND: begin
            if (land_rd_ff) begin
               state_in = ogic_pkg::ST_RESP;
            end else begin
               land_we  = 1'b1;
               par_we   = 1'b1;
               size_we  = 1'b1;
               total_in = total_ff + CW'(1);
               dir_in   = ogic_pkg::DIR_UP;
               state_in = ogic_pkg::ST_NBR;
            end
         end
         ogic_pkg::ST_NBR: begin
            if (nb_ok) begin
               adj_in   = adj_calc;
               land_ra  = adj_calc;
               state_in = ogic_pkg::ST_NBR_LAND;
            end else if (dir_ff == ogic_pkg::DIR_LEFT) begin
               state_in = ogic_pkg::ST_RESP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         ogic_pkg::ST_NBR_LAND: begin
            if (land_rd_ff) begin
               cur_in    = node_ff;
               par_ra    = node_ff;
               second_in = 1'b0;
               state_in  = ogic_pkg::ST_FIND;
            end else if (dir_ff == ogic_pkg::DIR_LEFT) begin
               state_in = ogic_pkg::ST_RESP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ogic_pkg::ST_NBR;
            end
         end
         ogic_pkg::ST_FIND: begin
            if (par_rd_ff != cur_ff) begin
               cur_in = par_rd_ff;
               par_ra = par_rd_ff;
            end else if (!second_ff) begin
               root_u_in = cur_ff;
               second_in = 1'b1;
               cur_in    = adj_ff;
               par_ra    = adj_ff;
            end else if (cur_ff != root_u_ff) begin
               total_in = total_ff - CW'(1);
               size_ra  = root_u_ff;
               state_in = ogic_pkg::ST_SIZE_A;
            end else if (dir_ff == ogic_pkg::DIR_LEFT) begin
               state_in = ogic_pkg::ST_RESP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ogic_pkg::ST_NBR;
            end
         end
         ogic_pkg::ST_SIZE_A: begin
            size_u_in = size_rd_ff;
            size_ra   = cur_ff;
            state_in  = ogic_pkg::ST_SIZE_B;
         end
         ogic_pkg::ST_SIZE_B: begin
            par_we  = 1'b1;
            size_we = 1'b1;
            size_wd = size_u_ff + size_rd_ff;
            if (size_u_ff > size_rd_ff) begin
               par_wa  = cur_ff;
               par_wd  = root_u_ff;
               size_wa = root_u_ff;
            end else begin
               par_wa  = root_u_ff;
               par_wd  = cur_ff;
               size_wa = cur_ff;
            end
            if (dir_ff == ogic_pkg::DIR_LEFT) begin
               state_in = ogic_pkg::ST_RESP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ogic_pkg::ST_NBR;
            end
         end
         ogic_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ogic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ogic_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ogic_pkg::ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         grid_rows_ff <= GW'(32);
         grid_cols_ff <= GW'(32);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         total_ff <= total_in;
         if (csr_chan.valid) begin
            if (csr_chan.reg_index == ogic_pkg::REG_GRID_ROWS) begin
               grid_rows_ff <= csr_chan.wr_data;
            end else begin
               grid_cols_ff <= csr_chan.wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      node_ff   <= node_in;
      adj_ff    <= adj_in;
      cur_ff    <= cur_in;
      root_u_ff <= root_u_in;
      size_u_ff <= size_u_in;
      dir_ff    <= dir_in;
      second_ff <= second_in;
      oor_ff    <= oor_in;
   end

   always_ff @(posedge clock) begin
      if (land_we) begin
         land_mem_ff[land_wa] <= land_wd;
      end
      land_rd_ff <= land_mem_ff[land_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem_ff[par_wa] <= par_wd;
      end
      par_rd_ff <= par_mem_ff[par_ra];
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem_ff[size_wa] <= size_wd;
      end
      size_rd_ff <= size_mem_ff[size_ra];
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.valid && req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ogic_pkg::ST_CLEAR) |-> !req_chan.ready)
      else $error("request taken during the clearing pass");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (total_ff == $past(total_ff) || total_ff == $past(total_ff) + 11'd1
                || total_ff == $past(total_ff) - 11'd1))
      else $error("island count moved by more than one in a cycle");

   a_merge_roots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ogic_pkg::ST_SIZE_B) |-> (cur_ff != root_u_ff))
      else $error("merge of a set with itself");

endmodule
`default_nettype wire
